@@ rtl/mexp_pkg.sv @@
// Shared constants for the modular exponentiation core: widths and register indexes.
package mexp_pkg;

    localparam int FIELD_W   = 63;
    localparam int TDATA_W   = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

    localparam logic [FIELD_W-1:0] EXPONENT_RST = 63'd65537;
    localparam logic [FIELD_W-1:0] MODULUS_RST  = 63'd1;

endpackage

@@ rtl/modular_exponentiation_core.sv @@
// Modular exponentiation core: base ^ exponent mod modulus, bit-serial square-and-multiply.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the exponent (index 0)
//   and the modulus (index 1); cfg_ready is always high. Write only while the core is idle.
//   s_ channel takes one base value per item; m_ channel returns one result per item.
//   Operands are taken in their low OPERAND_BITS bits.
// Sequence, with N = OPERAND_BITS: a zero exponent or a modulus of 0 or 1 goes straight
//   to the hold state. Otherwise the single shift-and-add modular multiplier, which
//   consumes one multiplier bit per cycle, runs the products in order: one product
//   reduces the base, then each of the N exponent bits costs a squaring plus a multiply
//   when the bit is set.
// Throughput: one item at a time; s_tready is high only while the engine is idle.
//   The result sits in an output register, so a new item is taken while the previous
//   result still waits on m_tready.
// Stall: a stalled receiver holds m_tvalid/m_tdata; a finished result then waits inside
//   the engine until the output register frees up.
// Reset: aresetn (synchronous, active low) empties the engine and output register and
//   loads exponent 65537 and modulus 1.
module modular_exponentiation_core #(
    parameter int OPERAND_BITS = 63
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mexp_pkg::FIELD_W-1:0]     cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mexp_pkg::TDATA_W-1:0]     s_tdata,   // [62:0] base_value, [63] zero
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mexp_pkg::TDATA_W-1:0]     m_tdata    // [62:0] power_result, [63] zero
);
    import mexp_pkg::*;

    localparam int N     = OPERAND_BITS;
    localparam int CNT_W = $clog2(N);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;
    typedef enum logic [1:0] {OP_REDUCE, OP_SQUARE, OP_MULT} op_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]   exp_cnt_reg, exp_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] exponent_reg, exponent_next;
    logic [FIELD_W-1:0] modulus_reg, modulus_next;

    logic [N-1:0]       m_reg, m_next;
    logic [N-1:0]       exp_reg, exp_next;
    logic [N-1:0]       base_reg, base_next;
    logic [N-1:0]       x_reg, x_next;
    logic [N-1:0]       y_reg, y_next;
    logic [N-1:0]       acc_reg, acc_next;
    logic [N-1:0]       val_reg, val_next;
    logic [N-1:0]       res_reg, res_next;

    // one multiplier bit per cycle: acc = 2*acc + (bit ? x : 0), both reduced mod m
    logic [N:0]   m_ext, dbl, sum;
    logic [N-1:0] red1, prod_w;
    logic         advance;

    always_comb begin
        m_ext  = {1'b0, m_reg};
        dbl    = {acc_reg, 1'b0};
        red1   = (dbl >= m_ext) ? N'(dbl - m_ext) : N'(dbl);
        sum    = {1'b0, red1} + (y_reg[N-1] ? {1'b0, x_reg} : {(N+1){1'b0}});
        prod_w = (sum >= m_ext) ? N'(sum - m_ext) : N'(sum);
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        bit_cnt_next   = bit_cnt_reg;
        exp_cnt_next   = exp_cnt_reg;
        out_valid_next = out_valid_reg;
        exponent_next  = exponent_reg;
        modulus_next   = modulus_reg;
        m_next         = m_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        advance        = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_EXPONENT: exponent_next = cfg_data;
                CFG_MODULUS:  modulus_next  = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    m_next   = modulus_reg[N-1:0];
                    exp_next = exponent_reg[N-1:0];
                    if (exponent_reg[N-1:0] == '0) begin
                        val_next   = N'(1);
                        state_next = ST_HOLD;
                    end else if (modulus_reg[N-1:0] <= N'(1)) begin
                        val_next   = '0;
                        state_next = ST_HOLD;
                    end else begin
                        // base mod m is the product 1 * base
                        op_next      = OP_REDUCE;
                        x_next       = N'(1);
                        y_next       = s_tdata[N-1:0];
                        acc_next     = '0;
                        bit_cnt_next = '0;
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                acc_next     = prod_w;
                y_next       = y_reg << 1;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == LAST) begin
                    acc_next     = '0;
                    bit_cnt_next = '0;
                    case (op_reg)
                        OP_REDUCE: begin
                            // leading zero exponent bits just square 1, so scan all N bits
                            base_next    = prod_w;
                            exp_cnt_next = '0;
                            op_next      = OP_SQUARE;
                            x_next       = N'(1);
                            y_next       = N'(1);
                        end
                        OP_SQUARE: begin
                            val_next = prod_w;
                            if (exp_reg[N-1]) begin
                                op_next = OP_MULT;
                                x_next  = prod_w;
                                y_next  = base_reg;
                            end else begin
                                advance = 1'b1;
                            end
                        end
                        OP_MULT: begin
                            val_next = prod_w;
                            advance  = 1'b1;
                        end
                        default: op_next = OP_REDUCE;
                    endcase
                    if (advance) begin
                        if (exp_cnt_reg == LAST) begin
                            state_next = ST_HOLD;
                        end else begin
                            exp_next     = exp_reg << 1;
                            exp_cnt_next = exp_cnt_reg + CNT_W'(1);
                            op_next      = OP_SQUARE;
                            x_next       = prod_w;
                            y_next       = prod_w;
                        end
                    end
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    res_next       = val_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        exp_reg  <= exp_next;
        base_reg <= base_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_REDUCE;
            bit_cnt_reg   <= '0;
            exp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            exponent_reg  <= EXPONENT_RST;
            modulus_reg   <= MODULUS_RST;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bit_cnt_reg   <= bit_cnt_next;
            exp_cnt_reg   <= exp_cnt_next;
            out_valid_reg <= out_valid_next;
            exponent_reg  <= exponent_next;
            modulus_reg   <= modulus_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'(res_reg);

`ifndef SYNTH
    a_acc_below_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (acc_reg < m_reg))
        else $error("partial product not reduced below modulus");

    a_base_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && op_reg != OP_REDUCE) |-> (base_reg < m_reg))
        else $error("reduced base not below modulus");

    a_zero_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && exponent_reg[N-1:0] == '0)
        |=> (state_reg == ST_HOLD && val_reg == N'(1)))
        else $error("zero exponent did not yield one");
`endif

endmodule

@@ tb/mexp_result_checker.sv @@
// Result checker for the modular exponentiation core: key tracking, prediction, compare.
`timescale 1ns / 1ps

module mexp_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mexp_pkg::FIELD_W-1:0]   cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mexp_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mexp_pkg::TDATA_W-1:0]   m_tdata,
    output int                             mismatches,
    output int                             outstanding
);
    import mexp_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] power;
    } power_entry_t;

    logic [FIELD_W-1:0] key_exponent = EXPONENT_RST;
    logic [FIELD_W-1:0] key_modulus  = MODULUS_RST;
    power_entry_t       power_queue[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // (a * b) mod m on a full double-width product
    function automatic logic [FIELD_W-1:0] mul_reduce(input logic [FIELD_W-1:0] a,
                                                      input logic [FIELD_W-1:0] b,
                                                      input logic [FIELD_W-1:0] m);
        logic [2*FIELD_W-1:0] prod;
        prod = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
        prod = prod % {{FIELD_W{1'b0}}, m};
        return prod[FIELD_W-1:0];
    endfunction

    // right-to-left binary exponentiation; same value as the core's left-to-right scan
    function automatic logic [FIELD_W-1:0] expected_power(input logic [FIELD_W-1:0] b,
                                                          input logic [FIELD_W-1:0] e,
                                                          input logic [FIELD_W-1:0] m);
        logic [FIELD_W-1:0] acc;
        logic [FIELD_W-1:0] sq;
        if (e == '0) begin
            return 1;
        end
        if (m <= 1) begin
            return '0;
        end
        acc = 1;
        sq  = b % m;
        for (int i = 0; i < FIELD_W; i++) begin
            if (e[i]) begin
                acc = mul_reduce(acc, sq, m);
            end
            sq = mul_reduce(sq, sq, m);
        end
        return acc;
    endfunction

    always @(posedge aclk) begin
        power_entry_t want;
        int           delta;
        delta = 0;
        if (!aresetn) begin
            key_exponent <= EXPONENT_RST;
            key_modulus  <= MODULUS_RST;
            power_queue.delete();
            outstanding  <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EXPONENT: begin
                        key_exponent <= cfg_data;
                    end
                    CFG_MODULUS: begin
                        key_modulus <= cfg_data;
                    end
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to an item taken at the same edge
            if (m_tvalid && m_tready) begin
                if (power_queue.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual %h",
                             $time, m_tdata[FIELD_W-1:0]);
                    mismatches <= mismatches + 1;
                end else begin
                    want  = power_queue.pop_front();
                    delta = delta - 1;
                    if (m_tdata[FIELD_W-1:0] !== want.power) begin
                        $display("%0t: power_result mismatch, base %h: expected %h, actual %h",
                                 $time, want.base, want.power, m_tdata[FIELD_W-1:0]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.base  = s_tdata[FIELD_W-1:0];
                want.power = expected_power(s_tdata[FIELD_W-1:0], key_exponent, key_modulus);
                power_queue.push_back(want);
                delta = delta + 1;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

@@ tb/tb_modular_exponentiation_core.sv @@
// Testbench top for the modular exponentiation core: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_modular_exponentiation_core;
    import mexp_pkg::*;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] TOP_BIT  = 63'h4000_0000_0000_0000;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 20000;   // longer than two worst-case exponentiations
    localparam int TAIL_CYCLES  = 8100;    // longer than one worst-case exponentiation
    localparam int IDLE_LIMIT   = 100000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPONENT;
    logic [FIELD_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // [62:0] base_value, [63] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // [62:0] power_result, [63] zero

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    modular_exponentiation_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mexp_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic logic [FIELD_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[FIELD_W-1:0];
    endfunction

    // offer one base; s_tvalid stays high on return so back-to-back items need no drop
    task automatic send_base(input logic [FIELD_W-1:0] base);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, base};
        do @(posedge aclk); while (!s_tready);
    endtask

    // write both key registers; only called with the core idle
    task automatic load_key(input logic [FIELD_W-1:0] exp_val,
                            input logic [FIELD_W-1:0] mod_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EXPONENT;
        cfg_data  <= exp_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_MODULUS;
        cfg_data  <= mod_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // receiver: short random stalls, one long hold-off on request
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_taken) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_taken = 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int                 items_left;
        int                 batch;
        int                 phase;
        logic [FIELD_W-1:0] exp_now;
        logic [FIELD_W-1:0] mod_now;
        logic [FIELD_W-1:0] base_now;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key: exponent 65537, modulus 1 -> all zero
        send_base('0);
        send_base(ALL_ONES);
        drain_results();
        // exponent zero gives one, even for modulus 1 and 0
        load_key('0, 63'd1);
        send_base(63'd5);
        send_base(ALL_ONES);
        drain_results();
        load_key('0, '0);
        send_base(ALL_ONES);
        drain_results();
        // modulus zero with nonzero exponent
        load_key(63'd65537, '0);
        send_base(63'd7);
        drain_results();
        // identity exponent, largest modulus, base at and around the modulus
        load_key(63'd1, ALL_ONES);
        send_base('0);
        send_base(63'd1);
        send_base(ALL_ONES);
        send_base(ALL_ONES - 63'd1);
        drain_results();
        // widest exponent: slowest case
        load_key(ALL_ONES, ALL_ONES);
        send_base(63'd2);
        send_base(ALL_ONES - 63'd1);
        drain_results();
        // small textbook key pair, base above modulus too
        load_key(63'd17, 63'd3233);
        send_base(63'd65);
        send_base(63'd3298);
        drain_results();
        load_key(63'd2753, 63'd3233);
        send_base(63'd2790);
        drain_results();
        load_key(63'd2, 63'd2);
        send_base(63'd3);
        drain_results();
        load_key(63'd5, TOP_BIT | 63'd1);
        send_base(ALL_ONES);
        send_base(TOP_BIT);
        drain_results();

        items_left = RANDOM_ITEMS;
        phase      = 0;
        while (items_left > 0) begin
            batch = $urandom_range(3, 12);
            if (batch > items_left) begin
                batch = items_left;
            end
            if (items_left <= 20) begin
                quiet = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: exp_now = '0;
                1: exp_now = $urandom_range(1, 16);
                2: exp_now = ALL_ONES;
                3: exp_now = 63'd65537;
                default: exp_now = rand_word();
            endcase
            case ($urandom_range(0, 9))
                0: mod_now = $urandom_range(0, 3);
                1: mod_now = rand_word() >> $urandom_range(1, 48);
                2: mod_now = ALL_ONES;
                3, 4: mod_now = rand_word() | TOP_BIT | 63'd1;
                default: mod_now = rand_word();
            endcase
            load_key(exp_now, mod_now);
            // receiver stalls long enough for the core to fill and block its input
            if (phase == 2) begin
                hold_req <= 1'b1;
                batch = (items_left < 4) ? items_left : 4;
            end
            repeat (batch) begin
                case ($urandom_range(0, 9))
                    0: base_now = '0;
                    1: base_now = ALL_ONES;
                    2: base_now = mod_now + $urandom_range(0, 5);
                    3: base_now = $urandom_range(0, 255);
                    default: base_now = rand_word();
                endcase
                send_base(base_now);
            end
            drain_results();
            items_left = items_left - batch;
            phase      = phase + 1;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
